// ===== src/avr_pkg.sv =====
// ----------------------------------------------------------------------------
// avr_pkg: shared types and constants for the axis vector rotation block
// Coordinate and angle widths, CORDIC constants, the arctangent table and
// the packed request and result types.
// ----------------------------------------------------------------------------
package avr_pkg;

	// Field widths
	localparam int COORD_WIDTH  = 32;
	localparam int ANGLE_WIDTH  = 16;

	// Phase word and trig format (Q2.30 with guard bits)
	localparam int PHASE_W      = 32;
	localparam int RESID_W      = PHASE_W - 2;
	localparam int TRIG_FRAC    = 30;
	localparam int TRIG_W       = 33;
	localparam int CORDIC_STEPS = 30;
	localparam int CORDIC_START = 652032874;

	// Multiplier operand split: trig word = hi * 2^SPLIT_LO + lo
	localparam int OPND_W       = COORD_WIDTH + 1;
	localparam int SPLIT_LO     = 16;
	localparam int HI_W         = TRIG_W - SPLIT_LO;
	localparam int PP_W         = OPND_W + HI_W;
	localparam int PROD_W       = OPND_W + TRIG_W;
	localparam int SUM_W        = PROD_W + 1;
	localparam int RND_W        = SUM_W - TRIG_FRAC;

	// Axis codes
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	// Request and result payloads
	typedef struct packed {
		logic [1:0]                    command;
		logic signed [COORD_WIDTH-1:0] in_x;
		logic signed [COORD_WIDTH-1:0] in_y;
		logic signed [COORD_WIDTH-1:0] in_z;
		logic [ANGLE_WIDTH-1:0]        angle;
	} vec_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] res_x;
		logic signed [COORD_WIDTH-1:0] res_y;
		logic signed [COORD_WIDTH-1:0] res_z;
		logic                          clipped;
	} rot_t;

	// CORDIC working vector and angle accumulator
	typedef struct packed {
		logic signed [TRIG_W-1:0] x;
		logic signed [TRIG_W-1:0] y;
		logic signed [TRIG_W-1:0] z;
	} cord_t;

	// Side data carried alongside the CORDIC
	typedef struct packed {
		logic [1:0]                    command;
		logic [1:0]                    quad;
		logic                          zero;
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic signed [COORD_WIDTH-1:0] z;
	} meta_t;

	// Partial products of one rotated term
	typedef struct packed {
		logic signed [PP_W-1:0] ac_hi;
		logic signed [PP_W-1:0] ac_lo;
		logic signed [PP_W-1:0] bs_hi;
		logic signed [PP_W-1:0] bs_lo;
	} pp_t;

	// Arctangent of 2^-step, in units of 2^32 per turn
	function automatic logic [PHASE_W-1:0] arc_angle(input int step);
		logic [PHASE_W-1:0] v;
		case (step)
			0:  v = 32'd536870912;
			1:  v = 32'd316933406;
			2:  v = 32'd167458907;
			3:  v = 32'd85004756;
			4:  v = 32'd42667331;
			5:  v = 32'd21354465;
			6:  v = 32'd10679838;
			7:  v = 32'd5340245;
			8:  v = 32'd2670163;
			9:  v = 32'd1335087;
			10: v = 32'd667544;
			11: v = 32'd333772;
			12: v = 32'd166886;
			13: v = 32'd83443;
			14: v = 32'd41722;
			15: v = 32'd20861;
			16: v = 32'd10430;
			17: v = 32'd5215;
			18: v = 32'd2608;
			19: v = 32'd1304;
			20: v = 32'd652;
			21: v = 32'd326;
			22: v = 32'd163;
			23: v = 32'd81;
			24: v = 32'd41;
			25: v = 32'd20;
			26: v = 32'd10;
			27: v = 32'd5;
			28: v = 32'd3;
			29: v = 32'd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== src/axis_vector_rotation.sv =====
// An accepted request passes cor_s[0]..cor_s[30], stages s1..s4 and the output register.
// One vector per cycle while vec_stall is low; the 30-stage CORDIC pipeline is most of the path.
// A skid stage behind the output register absorbs one result when rot_stall rises,
// so vec_stall is a registered signal.
// Reset clears the valid bits of every stage and of the output; data registers keep no reset.
// ----------------------------------------------------------------------------
// axis_vector_rotation: principal-axis rotation of a 3D vector
// Rotates a Q16.16 vector about X, Y or Z by a binary angle. Sine and cosine
// come from a pipelined CORDIC; products are split and summed over three
// stages, then rounded and saturated.
// ----------------------------------------------------------------------------
module axis_vector_rotation
	import avr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic vec_valid,
	output logic vec_stall,
	input  vec_t vec,
	output logic rot_valid,
	input  logic rot_stall,
	output rot_t rot
);

	localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(64'd1 << TRIG_FRAC);
	localparam logic signed [TRIG_W-1:0] CORD_X0  = TRIG_W'(CORDIC_START);
	localparam logic signed [SUM_W-1:0]  RND_HALF = SUM_W'(64'd1 << (TRIG_FRAC - 1));
	localparam logic signed [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam logic signed [TRIG_W-1:0] Z_TOL    = TRIG_W'(1024);

	// Pipeline advance: held only while the skid stage is occupied
	logic en;

	// Stage valid bits
	logic [CORDIC_STEPS:0] vld_c;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	// CORDIC stages
	cord_t cor_s  [0:CORDIC_STEPS];
	meta_t meta_s [0:CORDIC_STEPS];
	cord_t cor_nx [0:CORDIC_STEPS-1];

	// Request decode
	logic [PHASE_W-1:0] phase_in;
	logic [RESID_W-1:0] resid_in;

	// Trig selection and operand stage
	logic signed [TRIG_W-1:0] c_nx, s_nx, c_s1, s_s1;
	logic signed [OPND_W-1:0] a_nx [2];
	logic signed [OPND_W-1:0] b_nx [2];
	logic signed [OPND_W-1:0] a_s1 [2];
	logic signed [OPND_W-1:0] b_s1 [2];
	meta_t meta_s1, meta_s2, meta_s3;

	// Products and sums
	pp_t pp_nx [2];
	pp_t pp_s2 [2];
	logic signed [PROD_W-1:0] pc_nx [2];
	logic signed [PROD_W-1:0] ps_nx [2];
	logic signed [PROD_W-1:0] pc_s3 [2];
	logic signed [PROD_W-1:0] ps_s3 [2];

	// Rounded and saturated terms
	logic signed [COORD_WIDTH-1:0] term [2];
	logic [1:0] term_clip;
	rot_t res_nx, res_s4;

	// Output register and skid stage
	logic out_vld_q, skid_vld_q;
	rot_t out_q, skid_q;

	assign en        = !skid_vld_q;
	assign vec_stall = skid_vld_q;
	assign rot_valid = out_vld_q;
	assign rot       = out_q;

	// Angle into phase word: top two bits are the quadrant
	assign phase_in = PHASE_W'(vec.angle) << (PHASE_W - ANGLE_WIDTH);
	assign resid_in = phase_in[RESID_W-1:0];

	// One CORDIC micro-rotation per stage
	always_comb begin
		logic signed [TRIG_W-1:0] dx, dy, arc;
		for (int k = 0; k < CORDIC_STEPS; k++) begin
			dx  = cor_s[k].y >>> k;
			dy  = cor_s[k].x >>> k;
			arc = $signed(TRIG_W'(arc_angle(k)));
			if (!cor_s[k].z[TRIG_W-1]) begin
				cor_nx[k].x = cor_s[k].x - dx;
				cor_nx[k].y = cor_s[k].y + dy;
				cor_nx[k].z = cor_s[k].z - arc;
			end else begin
				cor_nx[k].x = cor_s[k].x + dx;
				cor_nx[k].y = cor_s[k].y - dy;
				cor_nx[k].z = cor_s[k].z + arc;
			end
		end
	end

	// Quadrant fold and operand choice per axis
	always_comb begin
		logic signed [TRIG_W-1:0] cx, sy;
		logic signed [OPND_W-1:0] xe, ye, ze;
		cx = cor_s[CORDIC_STEPS].x;
		sy = cor_s[CORDIC_STEPS].y;
		if (meta_s[CORDIC_STEPS].zero) begin
			cx = TRIG_ONE;
			sy = '0;
		end
		case (meta_s[CORDIC_STEPS].quad)
			2'd0: begin c_nx = cx;  s_nx = sy;  end
			2'd1: begin c_nx = -sy; s_nx = cx;  end
			2'd2: begin c_nx = -cx; s_nx = -sy; end
			default: begin c_nx = sy; s_nx = -cx; end
		endcase
		xe = {meta_s[CORDIC_STEPS].x[COORD_WIDTH-1], meta_s[CORDIC_STEPS].x};
		ye = {meta_s[CORDIC_STEPS].y[COORD_WIDTH-1], meta_s[CORDIC_STEPS].y};
		ze = {meta_s[CORDIC_STEPS].z[COORD_WIDTH-1], meta_s[CORDIC_STEPS].z};
		case (meta_s[CORDIC_STEPS].command)
			AXIS_X: begin
				a_nx[0] = ye; b_nx[0] = ze;
				a_nx[1] = ze; b_nx[1] = -ye;
			end
			AXIS_Y: begin
				a_nx[0] = ze; b_nx[0] = xe;
				a_nx[1] = xe; b_nx[1] = -ze;
			end
			default: begin
				a_nx[0] = xe; b_nx[0] = ye;
				a_nx[1] = ye; b_nx[1] = -xe;
			end
		endcase
	end

	// Split multiplies: trig word as signed high half and unsigned low half
	always_comb begin
		logic signed [HI_W-1:0] c_hi, s_hi, c_lo, s_lo;
		c_hi = c_s1[TRIG_W-1:SPLIT_LO];
		s_hi = s_s1[TRIG_W-1:SPLIT_LO];
		c_lo = $signed({1'b0, c_s1[SPLIT_LO-1:0]});
		s_lo = $signed({1'b0, s_s1[SPLIT_LO-1:0]});
		for (int t = 0; t < 2; t++) begin
			pp_nx[t].ac_hi = a_s1[t] * c_hi;
			pp_nx[t].ac_lo = a_s1[t] * c_lo;
			pp_nx[t].bs_hi = b_s1[t] * s_hi;
			pp_nx[t].bs_lo = b_s1[t] * s_lo;
		end
	end

	// Recombine partial products
	always_comb begin
		for (int t = 0; t < 2; t++) begin
			pc_nx[t] = (PROD_W'(pp_s2[t].ac_hi) <<< SPLIT_LO) + PROD_W'(pp_s2[t].ac_lo);
			ps_nx[t] = (PROD_W'(pp_s2[t].bs_hi) <<< SPLIT_LO) + PROD_W'(pp_s2[t].bs_lo);
		end
	end

	// Round half up, drop fraction, saturate
	always_comb begin
		logic signed [SUM_W-1:0] sum;
		logic signed [RND_W-1:0] rq;
		logic [RND_W-COORD_WIDTH:0] top;
		for (int t = 0; t < 2; t++) begin
			sum = SUM_W'(pc_s3[t]) - SUM_W'(ps_s3[t]) + RND_HALF;
			rq  = sum[SUM_W-1:TRIG_FRAC];
			top = rq[RND_W-1:COORD_WIDTH-1];
			if (top == '0 || top == '1) begin
				term[t]      = rq[COORD_WIDTH-1:0];
				term_clip[t] = 1'b0;
			end else begin
				term[t]      = rq[RND_W-1] ? SAT_MIN : SAT_MAX;
				term_clip[t] = 1'b1;
			end
		end
	end

	// Put rotated terms back on their axes
	always_comb begin
		res_nx.res_x   = meta_s3.x;
		res_nx.res_y   = meta_s3.y;
		res_nx.res_z   = meta_s3.z;
		res_nx.clipped = 1'b0;
		case (meta_s3.command)
			AXIS_X: begin
				res_nx.res_y   = term[0];
				res_nx.res_z   = term[1];
				res_nx.clipped = |term_clip;
			end
			AXIS_Y: begin
				res_nx.res_z   = term[0];
				res_nx.res_x   = term[1];
				res_nx.clipped = |term_clip;
			end
			AXIS_Z: begin
				res_nx.res_x   = term[0];
				res_nx.res_y   = term[1];
				res_nx.clipped = |term_clip;
			end
			default: begin
				res_nx.clipped = 1'b0;
			end
		endcase
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c  <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_c  <= {vld_c[CORDIC_STEPS-1:0], vec_valid};
			vld_s1 <= vld_c[CORDIC_STEPS];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Stage data
	always_ff @(posedge clk) begin
		if (en) begin
			cor_s[0].x          <= CORD_X0;
			cor_s[0].y          <= '0;
			cor_s[0].z          <= $signed(TRIG_W'(resid_in));
			meta_s[0].command   <= vec.command;
			meta_s[0].quad      <= phase_in[PHASE_W-1 -: 2];
			meta_s[0].zero      <= (resid_in == '0);
			meta_s[0].x         <= vec.in_x;
			meta_s[0].y         <= vec.in_y;
			meta_s[0].z         <= vec.in_z;
			for (int k = 0; k < CORDIC_STEPS; k++) begin
				cor_s[k+1]  <= cor_nx[k];
				meta_s[k+1] <= meta_s[k];
			end
			c_s1    <= c_nx;
			s_s1    <= s_nx;
			a_s1    <= a_nx;
			b_s1    <= b_nx;
			meta_s1 <= meta_s[CORDIC_STEPS];
			pp_s2   <= pp_nx;
			meta_s2 <= meta_s1;
			pc_s3   <= pc_nx;
			ps_s3   <= ps_nx;
			meta_s3 <= meta_s2;
			res_s4  <= res_nx;
		end
	end

	// Output register and skid control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (!rot_stall) begin
				skid_vld_q <= 1'b0;
			end
		end else if (vld_s4) begin
			if (!out_vld_q || !rot_stall) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (!rot_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	// Output register and skid data
	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (!rot_stall) begin
				out_q <= skid_q;
			end
		end else if (vld_s4) begin
			if (!out_vld_q || !rot_stall) begin
				out_q <= res_s4;
			end else begin
				skid_q <= res_s4;
			end
		end
	end

	// Skid stage only holds a result while the output register is full
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		vec_stall |-> rot_valid)
		else $error("skid stage occupied with empty output register");

	// Skid stage fills only on a stalled, full output
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && rot_stall))
		else $error("skid stage filled without output stall");

	// A clipped result has at least one coordinate on a bound
	a_clip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(rot_valid && rot.clipped) |->
		(rot.res_x == SAT_MAX || rot.res_x == SAT_MIN ||
		 rot.res_y == SAT_MAX || rot.res_y == SAT_MIN ||
		 rot.res_z == SAT_MAX || rot.res_z == SAT_MIN))
		else $error("clipped flag without saturated coordinate");

	// CORDIC angle accumulator has converged at the last stage
	a_cordic_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_c[CORDIC_STEPS] && !meta_s[CORDIC_STEPS].zero) |->
		(cor_s[CORDIC_STEPS].z < Z_TOL && cor_s[CORDIC_STEPS].z > -Z_TOL))
		else $error("CORDIC residual angle did not converge");

endmodule
